/* src/ffpa_pkg.sv */
`timescale 1ns / 1ps
package ffpa_pkg;

  localparam int POOL_BYTES   = 1024;
  localparam int HEADER_BYTES = 8;
  localparam int SPLIT_SLACK  = 8;

  localparam int ADDR_W = 10;                  // byte offset inside the pool
  localparam int SIZE_W = 11;                  // stored size, saturates at POOL_BYTES
  localparam int CUR_W  = 12;                  // walk cursor and block end sums
  localparam int HDR_W  = SIZE_W + 1;
  localparam int STEP_W = 5;

  localparam logic [CUR_W-1:0]  HB_C    = CUR_W'(HEADER_BYTES);
  localparam logic [CUR_W-1:0]  SPLIT_C = CUR_W'(HEADER_BYTES + SPLIT_SLACK);
  localparam logic [CUR_W-1:0]  POOL_C  = CUR_W'(POOL_BYTES);
  localparam logic [SIZE_W-1:0] POOL_SZ = SIZE_W'(POOL_BYTES);

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_ZERO  = 2'd1,
    ST_FULL  = 2'd2,
    ST_FREED = 2'd3
  } status_t;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_RES_ZERO,
    OP_READ_I,
    OP_LOAD_CUR,
    OP_ADV_I,
    OP_TAKE,
    OP_SPLIT,
    OP_RES_FULL,
    OP_CARVE,
    OP_RES_FREED,
    OP_READ_H,
    OP_MARK_H,
    OP_READ_END,
    OP_MERGE_NEXT,
    OP_CLR_I,
    OP_MERGE_PREV,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_IS_FREE,
    C_REQ_ZERO,
    C_I_GE_TOP,
    C_FIT,
    C_NO_SPLIT,
    C_NO_ROOM,
    C_ADDR_LOW,
    C_END_GE_TOP,
    C_PREV_HIT,
    C_OUT_BLOCKED
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  localparam step_t S_IDLE    = 5'd0;
  localparam step_t S_A_LOOP  = 5'd3;
  localparam step_t S_A_TAKE  = 5'd6;
  localparam step_t S_A_TOP   = 5'd8;
  localparam step_t S_F_CHK   = 5'd10;
  localparam step_t S_F_WALK  = 5'd15;
  localparam step_t S_F_LOOP  = 5'd16;
  localparam step_t S_F_MERGE = 5'd19;
  localparam step_t S_EMIT    = 5'd20;

  // Control store: the step counter moves to target when cond holds, else to the next step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      5'd0:  w = '{OP_LATCH,      C_NO_ACCEPT,   S_IDLE};
      5'd1:  w = '{OP_NONE,       C_IS_FREE,     S_F_CHK};
      5'd2:  w = '{OP_RES_ZERO,   C_REQ_ZERO,    S_EMIT};
      5'd3:  w = '{OP_READ_I,     C_I_GE_TOP,    S_A_TOP};
      5'd4:  w = '{OP_LOAD_CUR,   C_FIT,         S_A_TAKE};
      5'd5:  w = '{OP_ADV_I,      C_ALWAYS,      S_A_LOOP};
      5'd6:  w = '{OP_TAKE,       C_NO_SPLIT,    S_EMIT};
      5'd7:  w = '{OP_SPLIT,      C_ALWAYS,      S_EMIT};
      5'd8:  w = '{OP_RES_FULL,   C_NO_ROOM,     S_EMIT};
      5'd9:  w = '{OP_CARVE,      C_ALWAYS,      S_EMIT};
      5'd10: w = '{OP_RES_FREED,  C_ADDR_LOW,    S_EMIT};
      5'd11: w = '{OP_READ_H,     C_NEVER,       S_IDLE};
      5'd12: w = '{OP_MARK_H,     C_NEVER,       S_IDLE};
      5'd13: w = '{OP_READ_END,   C_END_GE_TOP,  S_F_WALK};
      5'd14: w = '{OP_MERGE_NEXT, C_NEVER,       S_IDLE};
      5'd15: w = '{OP_CLR_I,      C_NEVER,       S_IDLE};
      5'd16: w = '{OP_READ_I,     C_I_GE_TOP,    S_EMIT};
      5'd17: w = '{OP_LOAD_CUR,   C_PREV_HIT,    S_F_MERGE};
      5'd18: w = '{OP_ADV_I,      C_ALWAYS,      S_F_LOOP};
      5'd19: w = '{OP_MERGE_PREV, C_ALWAYS,      S_EMIT};
      5'd20: w = '{OP_EMIT,       C_OUT_BLOCKED, S_EMIT};
      default: w = '{OP_NONE,     C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [SIZE_W-1:0] sat_size(logic [CUR_W-1:0] v);
    return (v > POOL_C) ? POOL_SZ : v[SIZE_W-1:0];
  endfunction

endpackage

/* src/first_fit_pool_allocator.sv */
`timescale 1ns / 1ps
// First-fit allocator over a 1024-byte pool with an 8-byte header per block. Each request
// beat on the slave side gives exactly one result beat on the master side: an allocation
// returns the payload offset of the first free block that fits (split when the leftover
// exceeds 16 bytes) or a block carved at the high-water mark, and a free marks the block
// free and merges it with free neighbours. Headers live in a 1024-entry single-port-read
// RAM with registered read, and a small microprogram steps through them. A zero size ends
// an allocation at once with a zero status; else it walks the headers until a fit or the
// high-water mark and takes the fit or carves a new block, or reports a full pool. A free
// of an address below the header ends at once; else it marks the header free, absorbs a
// free successor, then walks the headers for a free block ending at its header and merges
// into it. The walk over the header RAM, one header at a time, sets how long an operation
// takes. Only one request is in flight; once the result has been placed in the output
// register, the microprogram passes an empty closing step before the slave side reopens.
module first_fit_pool_allocator
  import ffpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] request_size, [19:10] free_address, rest zero
  input  logic        s_tuser,   // [0] kind: 0 allocate, 1 free
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [9:0] address, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  step_t  upc, upc_next;
  uword_t uw;
  logic   cond_true;

  logic              kind;
  logic [ADDR_W-1:0] req;
  logic [ADDR_W-1:0] faddr;
  logic [CUR_W-1:0]  cur_i;
  logic [SIZE_W-1:0] top;
  hdr_t              cur;
  logic [SIZE_W-1:0] sz_h;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;

  logic              out_valid;
  status_t           out_status;
  logic [ADDR_W-1:0] out_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  hdr_t              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [HDR_W-1:0]  ram_rdata;
  hdr_t              rd;

  logic [ADDR_W-1:0] h;
  logic [CUR_W-1:0]  req_x;
  logic [CUR_W-1:0]  top_x;
  logic [CUR_W-1:0]  end_h;
  logic [CUR_W-1:0]  rd_end;
  logic [CUR_W-1:0]  cur_end;
  logic [CUR_W-1:0]  split_at;
  logic [SIZE_W-1:0] rest;
  logic              do_split;
  logic [CUR_W-1:0]  top_end;
  logic [SIZE_W-1:0] next_merged;
  logic [SIZE_W-1:0] prev_merged;
  logic              out_load;

  assign rd        = hdr_t'(ram_rdata);
  assign uw        = ucode(upc);
  assign h         = faddr - ADDR_W'(HEADER_BYTES);
  assign req_x     = CUR_W'(req);
  assign top_x     = CUR_W'(top);
  assign end_h     = CUR_W'(h) + HB_C + CUR_W'(sz_h);
  assign rd_end    = cur_i + HB_C + CUR_W'(rd.size);
  assign cur_end   = cur_i + HB_C + CUR_W'(cur.size);
  assign split_at  = cur_i + HB_C + req_x;
  assign rest      = cur.size - SIZE_W'(req);
  assign do_split  = CUR_W'(rest) > SPLIT_C;
  assign top_end   = top_x + HB_C + req_x;
  assign next_merged = sat_size(CUR_W'(sz_h) + HB_C + CUR_W'(rd.size));
  assign prev_merged = sat_size(CUR_W'(cur.size) + HB_C + CUR_W'(sz_h));
  assign out_load  = (uw.op == OP_EMIT) && (!out_valid || m_tready);

  assign s_tready  = (upc == S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = 16'(out_addr);
  assign m_tuser   = out_status;

  // Branch conditions; those on the fit and on the preceding block look at fresh RAM data.
  always_comb begin
    case (uw.cond)
      C_NEVER:       cond_true = 1'b0;
      C_ALWAYS:      cond_true = 1'b1;
      C_NO_ACCEPT:   cond_true = !s_tvalid;
      C_IS_FREE:     cond_true = kind;
      C_REQ_ZERO:    cond_true = (req == '0);
      C_I_GE_TOP:    cond_true = (cur_i >= top_x);
      C_FIT:         cond_true = rd.free && (rd.size >= SIZE_W'(req));
      C_NO_SPLIT:    cond_true = !do_split;
      C_NO_ROOM:     cond_true = (top_end > POOL_C);
      C_ADDR_LOW:    cond_true = (faddr < ADDR_W'(HEADER_BYTES));
      C_END_GE_TOP:  cond_true = (end_h >= top_x);
      C_PREV_HIT:    cond_true = rd.free && (rd_end == CUR_W'(h));
      C_OUT_BLOCKED: cond_true = out_valid && !m_tready;
      default:       cond_true = 1'b0;
    endcase
  end

  always_comb begin
    upc_next = cond_true ? uw.target : upc + step_t'(1);
  end

  always_comb begin
    case (uw.op)
      OP_READ_H:   ram_raddr = h;
      OP_READ_END: ram_raddr = end_h[ADDR_W-1:0];
      default:     ram_raddr = cur_i[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_i[ADDR_W-1:0];
    ram_wdata = '{free: 1'b0, size: cur.size};
    case (uw.op)
      OP_TAKE: begin
        ram_we    = 1'b1;
        ram_wdata = '{free: 1'b0, size: do_split ? SIZE_W'(req) : cur.size};
      end
      OP_SPLIT: begin
        // A leftover header that would fall off the end of the pool is dropped.
        ram_we    = (split_at < POOL_C);
        ram_waddr = split_at[ADDR_W-1:0];
        ram_wdata = '{free: 1'b1, size: rest - SIZE_W'(HEADER_BYTES)};
      end
      OP_CARVE: begin
        ram_we    = 1'b1;
        ram_waddr = top[ADDR_W-1:0];
        ram_wdata = '{free: 1'b0, size: SIZE_W'(req)};
      end
      OP_MARK_H: begin
        ram_we    = 1'b1;
        ram_waddr = h;
        ram_wdata = '{free: 1'b1, size: rd.size};
      end
      OP_MERGE_NEXT: begin
        ram_we    = rd.free;
        ram_waddr = h;
        ram_wdata = '{free: 1'b1, size: next_merged};
      end
      OP_MERGE_PREV: begin
        ram_we    = 1'b1;
        ram_wdata = '{free: cur.free, size: prev_merged};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= S_IDLE;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (uw.op == OP_CARVE) begin
        top <= top_end[SIZE_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LATCH: begin
        if (s_tvalid) begin
          kind  <= s_tuser;
          req   <= s_tdata[9:0];
          faddr <= s_tdata[19:10];
          cur_i <= '0;
        end
      end
      OP_RES_ZERO: begin
        res_status <= ST_ZERO;
        res_addr   <= '0;
      end
      OP_LOAD_CUR: cur   <= rd;
      OP_ADV_I:    cur_i <= cur_end;
      OP_CLR_I:    cur_i <= '0;
      OP_TAKE: begin
        res_status <= ST_ALLOC;
        res_addr   <= ADDR_W'(cur_i + HB_C);
      end
      OP_RES_FULL: begin
        res_status <= ST_FULL;
        res_addr   <= '0;
      end
      OP_CARVE: begin
        res_status <= ST_ALLOC;
        res_addr   <= ADDR_W'(top_x + HB_C);
      end
      OP_RES_FREED: begin
        res_status <= ST_FREED;
        res_addr   <= '0;
      end
      OP_MARK_H: sz_h <= rd.size;
      OP_MERGE_NEXT: begin
        if (rd.free) begin
          sz_h <= next_merged;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

  ffpa_ram #(
    .WIDTH(HDR_W),
    .DEPTH(POOL_BYTES)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(HDR_W'(ram_wdata)),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

/* src/ffpa_ram.sv */
`timescale 1ns / 1ps
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ffpa_checker.sv */
`timescale 1ns / 1ps
module ffpa_checker
  import ffpa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // Only one request is in flight, so the slave side closes right after a beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in flight");

  // A granted block always sits past its own header.
  a_alloc_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_ALLOC) |-> m_tdata[9:0] >= 10'(HEADER_BYTES))
    else $error("allocated address inside a header");

  // Every status other than a grant carries a zero address.
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_ALLOC) |-> m_tdata == 16'd0)
    else $error("non-zero address on a refusal or a free");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not quiet after reset");

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (.*);
